### hdl/vsc_pkg.sv
// Shared types and constants for the voice segment capture block.
package vsc_pkg;

   localparam int RING_DEPTH    = 4096;
   localparam int SEGMENT_DEPTH = 65536;
   localparam int RING_AW       = $clog2(RING_DEPTH);
   localparam int SEG_AW        = $clog2(SEGMENT_DEPTH);
   localparam int FILL_W        = SEG_AW + 1;
   localparam int CNT_W         = RING_AW + 1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [2:0] CSR_GROUP_SHIFT = 3'd0;
   localparam logic [2:0] CSR_MUTED       = 3'd1;
   localparam logic [2:0] CSR_START_LEVEL = 3'd2;
   localparam logic [2:0] CSR_QUIET_LEVEL = 3'd3;
   localparam logic [2:0] CSR_HANGOVER    = 3'd4;
   localparam logic [2:0] CSR_PREROLL     = 3'd5;

   localparam logic [1:0]  RST_GROUP_SHIFT = 2'd0;
   localparam logic        RST_MUTED       = 1'b0;
   localparam logic [14:0] RST_START_LEVEL = 15'd24000;
   localparam logic [14:0] RST_QUIET_LEVEL = 15'd8000;
   localparam logic [15:0] RST_HANGOVER    = 16'd8000;
   localparam logic [11:0] RST_PREROLL     = 12'd2000;

   // Largest group is four raw samples.
   localparam logic [1:0] MAX_SHIFT = 2'd2;

   typedef struct packed {
      logic               op;
      logic signed [15:0] raw_sample;
      logic [15:0]        read_index;
   } vsc_req_type;

   typedef struct packed {
      logic               recording;
      logic               segment_done;
      logic               segment_full;
      logic [16:0]        segment_length;
      logic signed [15:0] read_value;
   } vsc_rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [15:0]        wr_data;
      logic               rd_en;
      logic [RING_AW-1:0] rd_addr;
   } ring_req_type;

endpackage

### hdl/vsc_ring.sv
// Pre-roll ring memory; entries not yet written since reset read as zero.
module vsc_ring import vsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ring_req_type       ring_req,
   output logic [RING_AW-1:0] wr_pos,
   output logic [15:0]        rd_data
);

   logic [15:0]        mem [RING_DEPTH];
   logic [RING_AW-1:0] wpos_ff, wpos_in;
   logic               wrapped_ff, wrapped_in;
   logic [15:0]        mem_q_ff;
   logic               hit_ff, hit_in;

   // Writes go in order from address zero, so an address is written once the
   // ring has wrapped or the address lies below the write position.
   always_comb begin
      wpos_in    = wpos_ff;
      wrapped_in = wrapped_ff;
      if (ring_req.wr_en) begin
         wpos_in = wpos_ff + RING_AW'(1);
         if (wpos_ff == RING_AW'(RING_DEPTH - 1)) begin
            wrapped_in = 1'b1;
         end
      end
      hit_in = wrapped_ff || (ring_req.rd_addr < wpos_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff    <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wpos_ff    <= wpos_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         mem[wpos_ff] <= ring_req.wr_data;
      end
      if (ring_req.rd_en) begin
         mem_q_ff <= mem[ring_req.rd_addr];
         hit_ff   <= hit_in;
      end
   end

   assign wr_pos  = wpos_ff;
   assign rd_data = hit_ff ? mem_q_ff : 16'd0;

endmodule

### hdl/voice_segment_capture.sv
// Top level of the voice segment capture block: sequencer and segment store.
//
// Words arrive on req_ (valid/ready) and each one returns exactly one word on
// rsp_. A sample word is summed into a group of 1, 2 or 4 raw samples; a closed
// group gives one averaged value that enters the pre-roll ring and, unless
// muted, drives start, append and hangover decisions. A read word returns a
// segment store entry, or zero at or beyond the written extent.
// The block handles one word at a time: req_ready is high only while the
// sequencer is idle. A read word passes execute, read-wait and post steps; a
// sample word skips the read wait. A sample that starts a segment adds the
// pre-roll copy and a write of its own value: the copy moves one word per cycle
// through the ring's single read port into the store's single write port.
// The output register lets the next request be accepted while a result still
// waits; if rsp_ready stays low, the following result holds the sequencer
// until the output register frees.
// Synchronous reset returns the sequencer to idle, loads the register reset
// values and empties the ring by its fill tracking; no clearing pass is run.
// Configuration writes on csr_ take effect at once and belong in idle periods.
module voice_segment_capture import vsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vsc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output vsc_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_RWAIT = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_LAST  = 3'd4;
   localparam logic [2:0] ST_POST  = 3'd5;

   logic [2:0]  state_ff, state_in;
   vsc_req_type req_ff, req_in;

   logic [1:0]  shift_ff;
   logic        muted_ff;
   logic [14:0] start_ff, quiet_lvl_ff;
   logic [15:0] hang_ff;
   logic [11:0] preroll_ff;

   logic signed [17:0] sum_ff, sum_in;
   logic [1:0]         gcount_ff, gcount_in;
   logic [FILL_W-1:0]  fill_ff, fill_in, extent_ff, extent_in;
   logic [15:0]        quiet_ff, quiet_in;
   logic               rec_ff, rec_in;
   logic [15:0]        word_ff, word_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [RING_AW-1:0] rp_ff, rp_in;
   logic               pend_ff, pend_in;

   logic               res_done_ff, res_done_in, res_full_ff, res_full_in;
   logic [16:0]        res_len_ff, res_len_in;
   logic [15:0]        res_rd_ff, res_rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vsc_rsp_type        rsp_data_ff, rsp_data_in;

   logic [15:0]        seg_mem [SEGMENT_DEPTH];
   logic [15:0]        seg_q_ff;
   logic               st_we;
   logic [SEG_AW-1:0]  st_waddr;
   logic [15:0]        st_wdata;

   ring_req_type       ring_req;
   logic [RING_AW-1:0] ring_wpos;
   logic [15:0]        ring_rdata;

   // Group averaging and level tests.
   logic [1:0]         sh;
   logic signed [17:0] sum_next, avg_full;
   logic [17:0]        bias;
   logic [2:0]         cnt_next;
   logic               close;
   logic [15:0]        value, q_inc;
   logic [17:0]        mag;
   logic [CNT_W-1:0]   copy_cnt;
   logic [FILL_W-1:0]  fill_inc;

   vsc_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .ring_req(ring_req),
      .wr_pos  (ring_wpos),
      .rd_data (ring_rdata)
   );

   always_comb begin
      sh       = (shift_ff > MAX_SHIFT) ? MAX_SHIFT : shift_ff;
      sum_next = sum_ff + {{2{req_ff.raw_sample[15]}}, req_ff.raw_sample};
      cnt_next = {1'b0, gcount_ff} + 3'd1;
      close    = cnt_next >= (3'd1 << sh);
      // Negative sums get a bias of n-1 so the shift truncates toward zero.
      bias     = sum_next[17] ? ((18'd1 << sh) - 18'd1) : 18'd0;
      avg_full = $signed(sum_next + bias) >>> sh;
      value    = avg_full[15:0];
      // A group left open across a shift change can average beyond 16 bits, so
      // the level tests use the full-width magnitude.
      mag      = avg_full[17] ? (~avg_full + 18'd1) : avg_full;
      q_inc    = (quiet_ff == 16'hFFFF) ? quiet_ff : quiet_ff + 16'd1;
      copy_cnt = (32'(preroll_ff) > 32'(RING_DEPTH)) ? CNT_W'(RING_DEPTH)
                                                     : CNT_W'(preroll_ff);
      fill_inc = fill_ff + FILL_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      sum_in       = sum_ff;
      gcount_in    = gcount_ff;
      fill_in      = fill_ff;
      extent_in    = extent_ff;
      quiet_in     = quiet_ff;
      rec_in       = rec_ff;
      word_in      = word_ff;
      left_in      = left_ff;
      rp_in        = rp_ff;
      pend_in      = 1'b0;
      res_done_in  = res_done_ff;
      res_full_in  = res_full_ff;
      res_len_in   = res_len_ff;
      res_rd_in    = res_rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      st_we        = 1'b0;
      st_waddr     = fill_ff[SEG_AW-1:0];
      st_wdata     = word_ff;
      ring_req     = '0;
      ring_req.wr_data = value;
      ring_req.rd_addr = rp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               res_done_in = 1'b0;
               res_full_in = 1'b0;
               res_len_in  = '0;
               res_rd_in   = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_POST;
            if (req_ff.op == OP_READ) begin
               state_in = ST_RWAIT;
            end else if (!close) begin
               sum_in    = sum_next;
               gcount_in = cnt_next[1:0];
            end else begin
               sum_in         = '0;
               gcount_in      = '0;
               word_in        = value;
               ring_req.wr_en = 1'b1;
               if (!muted_ff) begin
                  if (rec_ff) begin
                     if (fill_ff < FILL_W'(SEGMENT_DEPTH)) begin
                        st_we     = 1'b1;
                        st_wdata  = value;
                        fill_in   = fill_inc;
                        extent_in = (fill_inc > extent_ff) ? fill_inc : extent_ff;
                        if (mag > {3'b000, quiet_lvl_ff}) begin
                           quiet_in = '0;
                        end else begin
                           quiet_in = q_inc;
                           if (q_inc >= hang_ff) begin
                              res_done_in = 1'b1;
                              res_len_in  = 17'(fill_inc);
                              rec_in      = 1'b0;
                              fill_in     = '0;
                              quiet_in    = '0;
                           end
                        end
                     end else begin
                        res_done_in = 1'b1;
                        res_full_in = 1'b1;
                        res_len_in  = 17'(fill_ff);
                        rec_in      = 1'b0;
                        fill_in     = '0;
                        quiet_in    = '0;
                     end
                  end else if (mag > {3'b000, start_ff}) begin
                     rec_in    = 1'b1;
                     fill_in   = '0;
                     quiet_in  = '0;
                     extent_in = '0;
                     left_in   = copy_cnt;
                     // Oldest copied entry, counted back from the slot written now.
                     rp_in     = RING_AW'(ring_wpos + RING_AW'(1) - copy_cnt[RING_AW-1:0]);
                     state_in  = ST_COPY;
                  end
               end
            end
         end
         ST_RWAIT: begin
            if (32'(req_ff.read_index) < 32'(extent_ff)) begin
               res_rd_in = seg_q_ff;
            end
            state_in = ST_POST;
         end
         ST_COPY: begin
            // Ring reads are issued one per cycle; each read word comes back in the next cycle.
            if (left_ff != '0) begin
               ring_req.rd_en = 1'b1;
               pend_in        = 1'b1;
               left_in        = left_ff - CNT_W'(1);
               rp_in          = rp_ff + RING_AW'(1);
            end
            if (pend_ff) begin
               st_we     = 1'b1;
               st_wdata  = ring_rdata;
               fill_in   = fill_inc;
               extent_in = (fill_inc > extent_ff) ? fill_inc : extent_ff;
            end
            if (left_ff == '0 && !pend_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            st_we     = 1'b1;
            st_wdata  = word_ff;
            fill_in   = fill_inc;
            extent_in = (fill_inc > extent_ff) ? fill_inc : extent_ff;
            state_in  = ST_POST;
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.recording      = rec_ff;
               rsp_data_in.segment_done   = res_done_ff;
               rsp_data_in.segment_full   = res_full_ff;
               rsp_data_in.segment_length = res_len_ff;
               rsp_data_in.read_value     = res_rd_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         gcount_ff    <= '0;
         fill_ff      <= '0;
         extent_ff    <= '0;
         quiet_ff     <= '0;
         rec_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= RST_GROUP_SHIFT;
         muted_ff     <= RST_MUTED;
         start_ff     <= RST_START_LEVEL;
         quiet_lvl_ff <= RST_QUIET_LEVEL;
         hang_ff      <= RST_HANGOVER;
         preroll_ff   <= RST_PREROLL;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         gcount_ff    <= gcount_in;
         fill_ff      <= fill_in;
         extent_ff    <= extent_in;
         quiet_ff     <= quiet_in;
         rec_ff       <= rec_in;
         pend_ff      <= pend_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GROUP_SHIFT: shift_ff     <= csr_data[1:0];
               CSR_MUTED:       muted_ff     <= csr_data[0];
               CSR_START_LEVEL: start_ff     <= csr_data[14:0];
               CSR_QUIET_LEVEL: quiet_lvl_ff <= csr_data[14:0];
               CSR_HANGOVER:    hang_ff      <= csr_data;
               CSR_PREROLL:     preroll_ff   <= csr_data[11:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      word_ff     <= word_in;
      rp_ff       <= rp_in;
      res_done_ff <= res_done_in;
      res_full_ff <= res_full_in;
      res_len_ff  <= res_len_in;
      res_rd_ff   <= res_rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         seg_mem[st_waddr] <= st_wdata;
      end
      seg_q_ff <= seg_mem[req_ff.read_index[SEG_AW-1:0]];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_extent_covers_fill: assert property (@(posedge clock) disable iff (reset)
      rec_ff |-> (extent_ff >= fill_ff))
      else $error("written extent fell below the fill count while recording");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(SEGMENT_DEPTH))
      else $error("fill count ran past the segment store");

   a_copy_while_recording: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY || state_ff == ST_LAST) |-> rec_ff)
      else $error("pre-roll copy running without an open segment");

   a_post_after_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> (state_ff == ST_POST))
      else $error("result word loaded outside the post step");
`endif

endmodule

### tb/tb_voice_segment_capture.sv
// Self-checking testbench for the voice segment capture block.
`timescale 1ns / 1ps

module tb_voice_segment_capture;
   import vsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int PHASES         = 10;
   localparam int PHASE_WORDS    = 16;

   typedef struct {
      bit [15:0] group_shift;
      bit [15:0] muted;
      bit [15:0] start_level;
      bit [15:0] quiet_level;
      bit [15:0] hangover;
      bit [15:0] preroll;
   } capture_settings_type;

   // Tracks the capture state and holds the result words still owed by the block.
   class segment_scoreboard;
      bit [1:0]    group_shift;
      bit          muted;
      bit [14:0]   start_level;
      bit [14:0]   quiet_level;
      bit [15:0]   hangover;
      bit [11:0]   preroll;
      int          group_acc;
      int          group_taken;
      bit [15:0]   ring [RING_DEPTH];
      int          ring_pos;
      bit [15:0]   store [SEGMENT_DEPTH];
      int          fill;
      int          extent;
      int          quiet_run;
      bit          active;
      vsc_rsp_type owed [$];
      int          errors;

      function new();
         group_shift = RST_GROUP_SHIFT;
         muted       = RST_MUTED;
         start_level = RST_START_LEVEL;
         quiet_level = RST_QUIET_LEVEL;
         hangover    = RST_HANGOVER;
         preroll     = RST_PREROLL;
      endfunction

      function void set_reg(logic [2:0] index, logic [15:0] data);
         case (index)
            CSR_GROUP_SHIFT: group_shift = data[1:0];
            CSR_MUTED:       muted       = data[0];
            CSR_START_LEVEL: start_level = data[14:0];
            CSR_QUIET_LEVEL: quiet_level = data[14:0];
            CSR_HANGOVER:    hangover    = data;
            CSR_PREROLL:     preroll     = data[11:0];
            default: ;
         endcase
      endfunction

      function void append(bit [15:0] w);
         store[fill % SEGMENT_DEPTH] = w;
         fill++;
         if (fill > extent) extent = fill;
      endfunction

      function void post_segment(inout vsc_rsp_type r, input bit full);
         r.segment_done   = 1'b1;
         r.segment_full   = full;
         r.segment_length = fill[16:0];
         active    = 1'b0;
         fill      = 0;
         quiet_run = 0;
      endfunction

      function void note_word(vsc_req_type w);
         vsc_rsp_type r;
         int          n;
         int          avg;
         int          mag;
         int          rp;
         bit [15:0]   v;
         r = '0;
         if (w.op == OP_READ) begin
            if (w.read_index < extent) r.read_value = store[w.read_index];
         end else begin
            n = 1 << ((group_shift > MAX_SHIFT) ? MAX_SHIFT : group_shift);
            group_acc += $signed(w.raw_sample);
            group_taken++;
            if (group_taken >= n) begin
               avg = group_acc / n;
               v   = avg[15:0];
               mag = (avg < 0) ? -avg : avg;
               group_acc   = 0;
               group_taken = 0;
               ring[ring_pos] = v;
               ring_pos = (ring_pos + 1) % RING_DEPTH;
               if (!muted) begin
                  if (active) begin
                     if (fill < SEGMENT_DEPTH) begin
                        append(v);
                        if (mag > quiet_level) begin
                           quiet_run = 0;
                        end else begin
                           if (quiet_run < 65535) quiet_run++;
                           if (quiet_run >= hangover) post_segment(r, 1'b0);
                        end
                     end else begin
                        // The value that finds the store full is dropped.
                        post_segment(r, 1'b1);
                     end
                  end else if (mag > start_level) begin
                     active    = 1'b1;
                     fill      = 0;
                     quiet_run = 0;
                     extent    = 0;
                     rp = (ring_pos + RING_DEPTH - preroll) % RING_DEPTH;
                     repeat (preroll) begin
                        append(ring[rp]);
                        rp = (rp + 1) % RING_DEPTH;
                     end
                     append(v);
                  end
               end
            end
         end
         r.recording = active;
         owed.push_back(r);
      endfunction

      function void fail(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) fail($sformatf("%s expected %0d got %0d", name, want, got));
      endfunction

      function void check_word(vsc_rsp_type got);
         vsc_rsp_type want;
         if (owed.size() == 0) begin
            fail($sformatf("result word %h arrived with none outstanding", got));
         end else begin
            want = owed.pop_front();
            check_field("recording", want.recording, got.recording);
            check_field("segment_done", want.segment_done, got.segment_done);
            check_field("segment_full", want.segment_full, got.segment_full);
            check_field("segment_length", want.segment_length, got.segment_length);
            check_field("read_value", want.read_value[15:0], got.read_value[15:0]);
         end
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   vsc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   vsc_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = CSR_GROUP_SHIFT;
   logic [15:0] csr_data  = '0;

   segment_scoreboard sb = new();

   int snd_idle_pct = 24;
   int rsp_idle_pct = 65;
   int holds_asked  = 0;
   int holds_served = 0;
   int hold_left    = 0;
   int stall_cycles = 0;

   int opening [7] = '{100, 20000, 32767, -32768, 1000, -1000, 0};
   int odd_group [5] = '{-1, -2, 0, 0, 7};

   voice_segment_capture dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_word(req_data);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic vsc_req_type sample_word(int v);
      vsc_req_type w;
      w.op         = OP_SAMPLE;
      w.raw_sample = v[15:0];
      w.read_index = 16'($urandom);
      return w;
   endfunction

   function automatic vsc_req_type read_word(int idx);
      vsc_req_type w;
      w.op         = OP_READ;
      w.raw_sample = 16'($urandom);
      w.read_index = idx[15:0];
      return w;
   endfunction

   // A raw sample whose magnitude is above the start level, with the given sign unless no positive value lies above it.
   function automatic int loud_value(int start, int neg);
      int m;
      if (start >= 32767 || (neg != 0 && $urandom_range(7) == 0)) return -32768;
      m = $urandom_range(start + 1, 32767);
      return (neg != 0) ? -m : m;
   endfunction

   function automatic int quiet_value(int q);
      int m;
      m = $urandom_range(0, q);
      return $urandom_range(1) ? -m : m;
   endfunction

   function automatic capture_settings_type phase_settings(int p);
      capture_settings_type s;
      s.group_shift = 16'(p % 4);
      s.muted       = 16'(p == 5);
      s.start_level = 16'((p == 1) ? 0 : (p == 2) ? 32767 : $urandom_range(1000, 30000));
      s.quiet_level = 16'((p == 3) ? 0 : (p == 4) ? 32767 : $urandom_range(0, 12000));
      s.hangover    = 16'((p == 6) ? 0 : (p == 7) ? 1 : (p == 8) ? 65535
                                                              : $urandom_range(2, 6));
      s.preroll     = 16'((p == 9) ? 4095 : (p == 0) ? 0 : $urandom_range(0, 20));
      return s;
   endfunction

   task automatic send_word(vsc_req_type w);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < snd_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Waits until every owed result has come back and the block has settled.
   // The first edge lets the monitor note a word accepted at the edge just seen.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(capture_settings_type s);
      logic [2:0]  regs [6] = '{CSR_GROUP_SHIFT, CSR_MUTED, CSR_START_LEVEL,
                                CSR_QUIET_LEVEL, CSR_HANGOVER, CSR_PREROLL};
      logic [15:0] vals [6];
      vals = '{s.group_shift, s.muted, s.start_level, s.quiet_level, s.hangover,
               s.preroll};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         sb.set_reg(regs[i], vals[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Mostly talk bursts followed by quiet samples meant to close the segment and a
   // few reads of it; the rest is unshaped samples and reads.
   task automatic run_phase(capture_settings_type s, int budget);
      int sent;
      int n;
      int len;
      int neg;
      sent = 0;
      n = 1 << ((s.group_shift > MAX_SHIFT) ? MAX_SHIFT : s.group_shift);
      while (sent < budget) begin
         if ($urandom_range(9) < 7) begin
            neg = $urandom_range(1);
            len = n * $urandom_range(1, 4);
            repeat (len) send_word(sample_word(loud_value(s.start_level, neg)));
            sent += len;
            len = n * (((s.hangover > 8) ? 8 : s.hangover) + $urandom_range(0, 2));
            repeat (len) send_word(sample_word(quiet_value(s.quiet_level)));
            sent += len;
            len = $urandom_range(1, 3);
            repeat (len) send_word(read_word($urandom_range(0, sb.extent + 2)));
            sent += len;
         end else if ($urandom_range(1)) begin
            send_word(sample_word($urandom));
            sent++;
         end else begin
            send_word(read_word($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      capture_settings_type s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words on a short pre-roll and hangover.
      s = '{16'd0, 16'd0, 16'd20000, 16'd1000, 16'd3, 16'd5};
      configure(s);
      send_word(read_word(0));
      send_word(read_word(16'hFFFF));
      foreach (opening[i]) send_word(sample_word(opening[i]));
      send_word(read_word(0));
      send_word(read_word(9));
      send_word(read_word(10));

      // Muting in the middle of a segment freezes it.
      send_word(sample_word(-20001));
      drain();
      s.muted = 1;
      configure(s);
      send_word(sample_word(0));
      drain();

      // Shift 3 groups four samples; the trailing sample is left open across
      // the switch back to single samples.
      s.muted       = 0;
      s.group_shift = 3;
      configure(s);
      foreach (odd_group[i]) send_word(sample_word(odd_group[i]));
      drain();
      s.group_shift = 0;
      s.hangover    = 1;
      configure(s);
      send_word(sample_word(5));
      drain();
      s.hangover = 0;
      configure(s);
      send_word(sample_word(32767));
      send_word(sample_word(32767));
      send_word(sample_word(1));
      send_word(read_word(1));

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES / 2) begin
            snd_idle_pct = 65;
            rsp_idle_pct = 24;
         end
         drain();
         s = phase_settings(p);
         configure(s);
         if (p == 1 || p == 6) holds_asked <= holds_asked + 1;
         run_phase(s, PHASE_WORDS);
      end

      // Longest pre-roll copy and reads around its end with no idling on either side.
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      drain();
      s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd4095};
      configure(s);
      send_word(sample_word(32767));
      send_word(sample_word(-32768));
      send_word(read_word(4095));
      send_word(read_word(4096));
      send_word(read_word(4097));
      send_word(read_word(16'hFFFF));
      repeat (10) send_word(read_word($urandom));
      drain();

      if (sb.owed.size() != 0)
         sb.fail($sformatf("%0d result words never arrived", sb.owed.size()));
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
